// ----- sv/trimmed_mean_sample_filter_unit_defines.svh -----
// Assertion macros for the trimmed-mean sample filter.
// Used by trimmed_mean_sample_filter_unit.sv; expects clk and rst_n in scope.
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TMSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TMSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMSF_ASSERT_IMPL(lbl, ante, cons, msg)
`define TMSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/tmsf_pkg.sv -----
// Package for the trimmed-mean sample filter: widths, defaults, cell control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tmsf_pkg;
  localparam int SAMPLE_BITS        = 12;
  localparam int MEAN_BITS          = 12;
  localparam int MEAN_SHIFT         = 3;
  localparam int DEF_BURST_LEN      = 16;
  localparam int DEF_TRIM_EACH_SIDE = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MEAN_BITS-1:0]   mean_t;

  // control handed from the sequencer to every cell
  typedef struct packed {
    logic ins;  // insert the incoming sample into the sorted row
    logic drn;  // shift the row one place toward cell 0
  } cell_ctl_t;
endpackage
`default_nettype wire

// ----- sv/tmsf_in_if.sv -----
// Sample input channel: valid/ready handshake with the sample payload.
// Depends on tmsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tmsf_in_if
  import tmsf_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ----- sv/tmsf_out_if.sv -----
// Result output channel: valid/ready handshake with the mean payload.
// Depends on tmsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tmsf_out_if
  import tmsf_pkg::*;
;
  logic  valid;
  logic  ready;
  mean_t mean;

  modport source (output valid, output mean, input ready);
  modport sink   (input valid, input mean, output ready);
endinterface
`default_nettype wire

// ----- sv/tmsf_cell.sv -----
// One cell of the sorting row: holds one sample, inserts or shifts with neighbors.
// Depends on tmsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmsf_cell
  import tmsf_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int CW       = 5
) (
  input  wire logic          clk,
  input  wire cell_ctl_t     ctl,
  input  wire sample_t       smp,
  input  wire logic [CW-1:0] cnt,
  input  wire sample_t       prev_val,
  input  wire logic          prev_gt,
  input  wire sample_t       next_val,
  output sample_t            val,
  output logic               gt
);
  sample_t val_r;
  sample_t val_nxt;
  logic    empty;

  // empty cells sort as larger than any sample
  assign empty = (CW'(CELL_IDX) >= cnt);
  assign gt    = empty || (val_r > smp);
  assign val   = val_r;

  // insert: first larger cell takes the sample, the ones after take their left neighbor
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && gt) begin
      val_nxt = prev_gt ? prev_val : smp;
    end else if (ctl.drn) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule
`default_nettype wire

// ----- sv/trimmed_mean_sample_filter_unit.sv -----
// Trimmed-mean sample filter, top level: sequencer, sorting row, accumulator.
// Depends on tmsf_pkg, tmsf_in_if, tmsf_out_if, tmsf_cell and the defines header.
//
// Usage:
//   in_ch  (sink)   : one 12-bit sample per transfer.
//   out_ch (source) : one 12-bit mean per burst of BURST_LEN samples.
// Each accepted sample is inserted into a row of BURST_LEN cells kept in
// ascending order, one sample per cycle while in_ch.ready is high. After the
// last sample of a burst the row shifts toward cell 0 in the drain state while
// the middle samples are summed; the hold state then scales and saturates the
// sum and loads the output register once that register is free. in_ch.ready
// is low in the drain and hold states.
// A waiting mean does not block sampling of the next burst; only when the
// next mean is ready and the old one is still untaken does the block hold.
// Reset (synchronous, rst_n low) empties the burst and drops any held mean.
`timescale 1ns / 1ps
`default_nettype none
`include "trimmed_mean_sample_filter_unit_defines.svh"
module trimmed_mean_sample_filter_unit
  import tmsf_pkg::*;
#(
  parameter int BURST_LEN      = DEF_BURST_LEN,
  parameter int TRIM_EACH_SIDE = DEF_TRIM_EACH_SIDE
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tmsf_in_if.sink     in_ch,
  tmsf_out_if.source  out_ch
);
  localparam int CW        = $clog2(BURST_LEN + 1);
  localparam int DRAIN_LEN = (BURST_LEN > TRIM_EACH_SIDE) ? BURST_LEN - TRIM_EACH_SIDE : 1;
  localparam int DW        = $clog2(BURST_LEN);
  localparam int SW        = SAMPLE_BITS + CW;
  localparam int MID_LO    = TRIM_EACH_SIDE;
  localparam int MID_HI    = BURST_LEN - TRIM_EACH_SIDE;  // exclusive

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [DW-1:0] didx_r, didx_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic          ov_r, ov_nxt;
  mean_t         mean_r, mean_nxt;
  logic          in_fire;
  logic          out_free;
  logic          in_mid;
  logic [SW-1:0] shifted;
  cell_ctl_t     ctl;

  sample_t vals [BURST_LEN];
  logic    gts  [BURST_LEN];

  assign in_ch.ready   = (st_r == ST_FILL);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_free      = !ov_r || out_ch.ready;
  assign out_ch.valid  = ov_r;
  assign out_ch.mean   = mean_r;
  assign ctl.ins       = in_fire;
  assign ctl.drn       = (st_r == ST_DRAIN);

  // row of cells, cell 0 holds the smallest sample
  for (genvar i = 0; i < BURST_LEN; i++) begin : g_cell
    sample_t pv, nv;
    logic    pg;
    if (i == 0) begin : g_first
      assign pv = '0;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pv = vals[i-1];
      assign pg = gts[i-1];
    end
    if (i == BURST_LEN - 1) begin : g_last
      assign nv = '0;
    end else begin : g_inner
      assign nv = vals[i+1];
    end
    tmsf_cell #(.CELL_IDX(i), .CW(CW)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .smp      (in_ch.sample),
      .cnt      (fcnt_r),
      .prev_val (pv),
      .prev_gt  (pg),
      .next_val (nv),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

  // drain position inside the kept middle of the burst
  assign in_mid  = (32'(didx_r) >= 32'(MID_LO)) && (32'(didx_r) < 32'(MID_HI));
  assign shifted = sum_r >> MEAN_SHIFT;

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    fcnt_nxt = fcnt_r;
    didx_nxt = didx_r;
    sum_nxt  = sum_r;
    ov_nxt   = ov_r;
    mean_nxt = mean_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      ST_FILL: begin
        if (in_fire) begin
          if (fcnt_r == CW'(BURST_LEN - 1)) begin
            fcnt_nxt = '0;
            didx_nxt = '0;
            sum_nxt  = '0;
            st_nxt   = ST_DRAIN;
          end else begin
            fcnt_nxt = fcnt_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (in_mid) begin
          sum_nxt = sum_r + SW'(vals[0]);
        end
        didx_nxt = didx_r + 1'b1;
        if (didx_r == DW'(DRAIN_LEN - 1)) begin
          st_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          mean_nxt = (shifted > SW'((1 << MEAN_BITS) - 1)) ? '1 : shifted[MEAN_BITS-1:0];
          st_nxt   = ST_FILL;
        end
      end
      default: st_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_FILL;
      fcnt_r <= '0;
      didx_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fcnt_r <= fcnt_nxt;
      didx_r <= didx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    mean_r <= mean_nxt;
  end

  // checks
  `TMSF_ASSERT_NEXT(a_last_starts_drain,
    in_fire && (fcnt_r == CW'(BURST_LEN - 1)), st_r == ST_DRAIN,
    "burst end did not start drain")
  `TMSF_ASSERT_IMPL(a_mean_from_hold, $rose(ov_r), $past(st_r) == ST_HOLD,
    "mean loaded outside hold")
  `TMSF_ASSERT_IMPL(a_row_sorted, (st_r == ST_FILL) && (fcnt_r >= CW'(2)),
    vals[0] <= vals[1], "row out of order")
  `TMSF_ASSERT_IMPL(a_fill_range, st_r == ST_FILL, fcnt_r < CW'(BURST_LEN),
    "fill count out of range")
endmodule
`default_nettype wire
